// ===== rtl/avm_pkg.sv =====
// Shared types and constants for the averaging voltmeter with two-digit display.
// Holds the beat structs, field widths, the segment table and digit helpers.
// No dependencies.
`timescale 1ns / 1ps

package avm_pkg;

	localparam int SAMPLE_W = 10;
	localparam int SUM_W    = 14;
	localparam int COUNT_W  = 4;
	localparam int VOLT_W   = 6;
	localparam int SEG_W    = 7;
	localparam int DIGIT_W  = 4;

	// Full-scale converter code and full-scale voltage in tenths
	localparam int FULL_CODE   = 1023;
	localparam int FULL_TENTHS = 33;

	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_TICK   = 1'b1;

	typedef struct packed {
		logic                mode;
		logic [SAMPLE_W-1:0] sample_value;
	} item_t;

	typedef struct packed {
		logic [SEG_W-1:0]  segments;
		logic              high_digit_enable;
		logic              low_digit_enable;
		logic [VOLT_W-1:0] shown_value;
	} result_t;

	localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};

	function automatic logic [DIGIT_W-1:0] tens_of(input logic [VOLT_W-1:0] v);
		logic [DIGIT_W-1:0] t;
		if (v >= VOLT_W'(60))
			t = DIGIT_W'(6);
		else if (v >= VOLT_W'(50))
			t = DIGIT_W'(5);
		else if (v >= VOLT_W'(40))
			t = DIGIT_W'(4);
		else if (v >= VOLT_W'(30))
			t = DIGIT_W'(3);
		else if (v >= VOLT_W'(20))
			t = DIGIT_W'(2);
		else if (v >= VOLT_W'(10))
			t = DIGIT_W'(1);
		else
			t = DIGIT_W'(0);
		return t;
	endfunction

	function automatic logic [SEG_W-1:0] digit_pattern(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] p;
		if (d > DIGIT_W'(9))
			p = SEG_TABLE[9];
		else
			p = SEG_TABLE[d];
		return p;
	endfunction

endpackage

// ===== rtl/avm_accum.sv =====
// Sample accumulator: sums a group of converter samples and, on the last one,
// scales the sum to tenths of a volt with a constant reciprocal multiply.
// Depends on avm_pkg.
`timescale 1ns / 1ps

module avm_accum import avm_pkg::*; #(
	parameter int SAMPLES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_en,
	input  logic [SAMPLE_W-1:0] sample_value,
	output logic [VOLT_W-1:0]   tenths
);

	localparam longint unsigned DIVISOR = longint'(SAMPLES) * FULL_CODE;
	localparam int              DIV_L   = $clog2(DIVISOR);
	localparam int              SHIFT   = SUM_W + 6 + DIV_L;
	localparam longint unsigned MAGIC   = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
	localparam longint unsigned K_VAL   = MAGIC * FULL_TENTHS;
	localparam int              KW      = $clog2(K_VAL + 1);
	localparam int              PROD_W  = SUM_W + KW;

	logic [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0] count_q;
	logic [VOLT_W-1:0]  tenths_q;
	logic [SUM_W-1:0]   sum_next;
	logic [COUNT_W:0]   count_next;
	logic               group_done;
	logic [KW-1:0]      k_const;
	logic [PROD_W-1:0]  product;

	assign sum_next   = sum_q + SUM_W'(sample_value);
	assign count_next = {1'b0, count_q} + (COUNT_W+1)'(1);
	assign group_done = count_next >= (COUNT_W+1)'(SAMPLES);
	assign k_const    = KW'(K_VAL);
	assign product    = PROD_W'(sum_next) * PROD_W'(k_const);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			count_q  <= '0;
			tenths_q <= '0;
		end else if (sample_en) begin
			if (group_done) begin
				sum_q    <= '0;
				count_q  <= '0;
				tenths_q <= product[SHIFT+VOLT_W-1:SHIFT];
			end else begin
				sum_q   <= sum_next;
				count_q <= count_next[COUNT_W-1:0];
			end
		end
	end

	assign tenths = tenths_q;

endmodule

// ===== rtl/avm_display.sv =====
// Display multiplexer: splits the held voltage into two digits and forms the
// segment beat for the digit whose turn it is, then flips to the other digit.
// Depends on avm_pkg.
`timescale 1ns / 1ps

module avm_display import avm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_en,
	input  logic [VOLT_W-1:0] tenths,
	output result_t           result
);

	logic               show_high_q;
	logic [DIGIT_W-1:0] tens;
	logic [DIGIT_W-1:0] units;
	logic [VOLT_W-1:0]  units_wide;

	assign tens       = tens_of(tenths);
	assign units_wide = tenths - VOLT_W'(tens) * VOLT_W'(10);
	assign units      = units_wide[DIGIT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			show_high_q <= 1'b1;
		end else if (tick_en) begin
			show_high_q <= !show_high_q;
		end
	end

	always_comb begin
		result.segments          = show_high_q ? digit_pattern(tens) : digit_pattern(units);
		result.high_digit_enable = show_high_q;
		result.low_digit_enable  = !show_high_q;
		result.shown_value       = tenths;
	end

endmodule

// ===== rtl/adc_average_voltmeter_display.sv =====
// Top level of the averaging voltmeter with two-digit seven-segment display.
// Instantiates avm_accum and avm_display; depends on avm_pkg.
//
//   beat      valid          stall          payload
//   input     item_valid     item_stall     item   (item_t: mode, sample_value)
//   output    result_valid   result_stall   result (result_t: segments, enables, value)
//
// One item per cycle while the input is not stalled: each item passes through the input
// register, and a refresh tick's beat is then registered into the output register.
// Sample items produce no output beat and never wait on the output side.
// A stalled output holds its beat; the input stalls only when a tick sits in
// the input register behind a full, stalled output register.
// Reset clears the sum, count and voltage, and selects the tens digit first.
`timescale 1ns / 1ps

module adc_average_voltmeter_display import avm_pkg::*; #(
	parameter int SAMPLES = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic              item_valid_s1;
	item_t             item_s1;
	logic              result_valid_q;
	result_t           result_q;
	logic              res_ready;
	logic              s1_go;
	logic              sample_en;
	logic              tick_en;
	logic [VOLT_W-1:0] tenths;
	result_t           disp_result;

	assign res_ready  = !result_valid_q || !result_stall;
	assign s1_go      = item_valid_s1 && (item_s1.mode == MODE_SAMPLE || res_ready);
	assign item_stall = item_valid_s1 && !s1_go;
	assign sample_en  = s1_go && item_s1.mode == MODE_SAMPLE;
	assign tick_en    = s1_go && item_s1.mode == MODE_TICK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	avm_accum #(
		.SAMPLES(SAMPLES)
	) u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.sample_en(sample_en),
		.sample_value(item_s1.sample_value),
		.tenths(tenths)
	);

	avm_display u_display (
		.clk(clk),
		.arst_n(arst_n),
		.tick_en(tick_en),
		.tenths(tenths),
		.result(disp_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_ready) begin
			result_valid_q <= tick_en;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_en) begin
			result_q <= disp_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== tb/sv/adc_average_voltmeter_display_tb.sv =====
// Testbench for adc_average_voltmeter_display: directed table, then random sample/tick beats.
// Checks every output beat against an in-bench model of the averaging and digit multiplexing.
// Depends on avm_pkg and the adc_average_voltmeter_display RTL.
`timescale 1ns / 1ps

module adc_average_voltmeter_display_tb import avm_pkg::*;;

	localparam int SAMPLES     = 8;
	localparam int PHASE_ITEMS = 283;

	typedef struct packed {
		item_t   stim;
		bit      typed;
		result_t want;
	} row_t;

	typedef struct packed {
		bit      typed;
		result_t want;
	} pinned_t;

	localparam row_t DIRECTED [22] = '{
		'{'{MODE_TICK,   10'h000}, 1'b1, '{7'h3F, 1'b1, 1'b0, 6'd0}},
		'{'{MODE_TICK,   10'h3FF}, 1'b1, '{7'h3F, 1'b0, 1'b1, 6'd0}},
		'{'{MODE_SAMPLE, 10'h3FF}, 1'b0, '0},
		'{'{MODE_SAMPLE, 10'h3FF}, 1'b0, '0},
		'{'{MODE_SAMPLE, 10'h3FF}, 1'b0, '0},
		'{'{MODE_SAMPLE, 10'h3FF}, 1'b0, '0},
		'{'{MODE_SAMPLE, 10'h3FF}, 1'b0, '0},
		'{'{MODE_SAMPLE, 10'h3FF}, 1'b0, '0},
		'{'{MODE_SAMPLE, 10'h3FF}, 1'b0, '0},
		'{'{MODE_SAMPLE, 10'h3FF}, 1'b0, '0},
		'{'{MODE_TICK,   10'h000}, 1'b1, '{7'h4F, 1'b1, 1'b0, 6'd33}},
		'{'{MODE_TICK,   10'h3FF}, 1'b1, '{7'h4F, 1'b0, 1'b1, 6'd33}},
		'{'{MODE_SAMPLE, 10'h000}, 1'b0, '0},
		'{'{MODE_SAMPLE, 10'h000}, 1'b0, '0},
		'{'{MODE_SAMPLE, 10'h000}, 1'b0, '0},
		'{'{MODE_SAMPLE, 10'h000}, 1'b0, '0},
		'{'{MODE_SAMPLE, 10'h2AA}, 1'b0, '0},
		'{'{MODE_SAMPLE, 10'h155}, 1'b0, '0},
		'{'{MODE_SAMPLE, 10'h3FF}, 1'b0, '0},
		'{'{MODE_SAMPLE, 10'h001}, 1'b0, '0},
		'{'{MODE_TICK,   10'h155}, 1'b0, '0},
		'{'{MODE_TICK,   10'h2AA}, 1'b0, '0}
	};

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	logic [SUM_W-1:0]  group_sum   = '0;
	int unsigned       group_count = 0;
	logic [VOLT_W-1:0] held_tenths = '0;
	bit                tens_next   = 1'b1;

	result_t readings_q [$];
	pinned_t pinned_q [$];
	int      sender_idle_pct    = 0;
	int      receiver_stall_pct = 0;
	bit      failed             = 1'b0;

	always #1 clk = ~clk;

	adc_average_voltmeter_display #(
		.SAMPLES(SAMPLES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	function automatic bit meter_step(input item_t stim, output result_t reading);
		int unsigned total;
		int unsigned digit;
		reading = '0;
		if (stim.mode == MODE_SAMPLE) begin
			total = group_sum + stim.sample_value;
			if (group_count + 1 >= SAMPLES) begin
				held_tenths = VOLT_W'((total * FULL_TENTHS) / (SAMPLES * FULL_CODE));
				group_sum   = '0;
				group_count = 0;
			end else begin
				group_sum   = SUM_W'(total);
				group_count = group_count + 1;
			end
			return 1'b0;
		end
		digit = tens_next ? held_tenths / 10 : held_tenths % 10;
		if (digit > 9)
			digit = 9;
		reading.segments          = SEG_TABLE[digit];
		reading.high_digit_enable = tens_next;
		reading.low_digit_enable  = !tens_next;
		reading.shown_value       = held_tenths;
		tens_next = !tens_next;
		return 1'b1;
	endfunction

	always @(posedge clk) begin
		result_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
	end

	always @(posedge clk) begin
		pinned_t pin;
		result_t reading;
		result_t want;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				pin = pinned_q.pop_front();
				if (meter_step(item, reading))
					readings_q.push_back(pin.typed ? pin.want : reading);
			end
			if (result_valid && !result_stall) begin
				if (readings_q.size() == 0) begin
					$display("%0t: beat with nothing expected, actual %p", $time, result);
					failed = 1'b1;
				end else begin
					want = readings_q.pop_front();
					if (result.segments !== want.segments) begin
						$display("%0t: segments expected %h actual %h",
							$time, want.segments, result.segments);
						failed = 1'b1;
					end
					if (result.high_digit_enable !== want.high_digit_enable) begin
						$display("%0t: high_digit_enable expected %b actual %b",
							$time, want.high_digit_enable, result.high_digit_enable);
						failed = 1'b1;
					end
					if (result.low_digit_enable !== want.low_digit_enable) begin
						$display("%0t: low_digit_enable expected %b actual %b",
							$time, want.low_digit_enable, result.low_digit_enable);
						failed = 1'b1;
					end
					if (result.shown_value !== want.shown_value) begin
						$display("%0t: shown_value expected %0d actual %0d",
							$time, want.shown_value, result.shown_value);
						failed = 1'b1;
					end
				end
			end
		end
	end

	task automatic send_beat(input item_t stim, input bit typed, input result_t want);
		pinned_t pin;
		pin.typed = typed;
		pin.want  = want;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		pinned_q.push_back(pin);
		item_valid <= 1'b1;
		item       <= stim;
		do @(posedge clk); while (item_stall);
	endtask

	// hold off until every pending reading has been seen
	task automatic wait_quiet();
		item_valid <= 1'b0;
		do @(posedge clk); while (readings_q.size() != 0 || pinned_q.size() != 0);
	endtask

	task automatic run_random(input int count);
		item_t stim;
		int    flavor;
		flavor = 0;
		for (int n = 0; n < count; n++) begin
			if (n % 16 == 0)
				flavor = $urandom_range(0, 3);
			stim.mode = ($urandom_range(0, 99) < 35) ? MODE_TICK : MODE_SAMPLE;
			case (flavor)
				0: stim.sample_value = SAMPLE_W'($urandom_range(900, 1023));
				1: stim.sample_value = SAMPLE_W'($urandom_range(0, 120));
				default: stim.sample_value = SAMPLE_W'($urandom());
			endcase
			send_beat(stim, 1'b0, '0);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED[i])
			send_beat(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want);
		wait_quiet();
		sender_idle_pct    = 35;
		receiver_stall_pct = 74;
		run_random(PHASE_ITEMS);
		wait_quiet();
		sender_idle_pct    = 74;
		receiver_stall_pct = 35;
		run_random(PHASE_ITEMS);
		wait_quiet();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		run_random(PHASE_ITEMS);
		wait_quiet();
		repeat (8) @(posedge clk);
		if (!failed)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#400000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
